// File: sv/bb3_pkg.sv
package bb3_pkg;

  localparam int CHAN_W    = 8;
  localparam int NUM_CHANS = 3;
  localparam int PIX_W     = CHAN_W * NUM_CHANS;
  localparam int NUM_LANES = 4;
  localparam int ROW_W     = 16;
  localparam int OCOL_W    = 10;
  localparam int SUM_W     = 12;
  localparam int NUM_W     = SUM_W + 1;
  localparam int CNT_W     = 4;
  localparam int RECIP_W   = 15;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 16;

  // Channel positions inside a pixel word
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // Lane holding the bottom-right output of the frame
  localparam logic [1:0] LANE_CORNER = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [10:0]      IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0] IMAGE_HEIGHT_RESET = 16'd1;

  // Reciprocals scaled by 2^16, exact for numerators below 4096
  localparam logic [RECIP_W-1:0] RECIP3 = 15'd21846;
  localparam logic [RECIP_W-1:0] RECIP9 = 15'd7282;

  typedef logic [NUM_CHANS-1:0][CHAN_W-1:0] pixel_t;

  // Index 0: two rows up, 1: one row up, 2: current row
  typedef pixel_t [2:0] column_t;

  // Index 0: two columns left, 1: one column left, 2: current column
  typedef column_t [2:0] win_t;

  typedef pixel_t [NUM_LANES-1:0] lane_px_t;

  typedef struct packed {
    logic load_sum;
    logic load_mean;
  } lane_ctrl_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] mask;
    logic [ROW_W-1:0]     row;
    logic [OCOL_W-1:0]    col;
  } grp_t;

endpackage

// File: sv/bb3_ram.sv
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bb3_lane.sv
module bb3_lane (
  input  logic               clk,
  input  bb3_pkg::lane_ctrl_t ctrl,
  input  bb3_pkg::win_t      win,
  input  logic [1:0]         row_skip,
  input  logic [1:0]         col_skip,
  output bb3_pkg::pixel_t    mean
);

  logic [1:0]                  nrows;
  logic [1:0]                  ncols;
  logic [bb3_pkg::CNT_W-1:0]   count_next;
  logic [bb3_pkg::SUM_W-1:0]   sum [bb3_pkg::NUM_CHANS];
  logic [bb3_pkg::NUM_W-1:0]   num_next [bb3_pkg::NUM_CHANS];

  logic [bb3_pkg::CNT_W-1:0]   count;
  logic [bb3_pkg::NUM_W-1:0]   num [bb3_pkg::NUM_CHANS];

  logic [bb3_pkg::SUM_W-1:0]   div_in [bb3_pkg::NUM_CHANS];
  logic [bb3_pkg::RECIP_W-1:0] recip;
  logic                        use_mul;
  logic [bb3_pkg::PROD_W-1:0]  prod [bb3_pkg::NUM_CHANS];
  logic [bb3_pkg::CHAN_W-1:0]  shifted [bb3_pkg::NUM_CHANS];
  bb3_pkg::pixel_t             mean_next;

  // Clipped window sum; the numerator 2*sum + count rounds half up
  always_comb begin
    nrows      = 2'd3 - row_skip;
    ncols      = 2'd3 - col_skip;
    count_next = bb3_pkg::CNT_W'(nrows) * bb3_pkg::CNT_W'(ncols);
    for (int ch = 0; ch < bb3_pkg::NUM_CHANS; ch++) begin
      sum[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (2'(c) >= col_skip && 2'(r) >= row_skip) begin
            sum[ch] = sum[ch] + bb3_pkg::SUM_W'(win[c][r][ch]);
          end
        end
      end
      num_next[ch] = {sum[ch], 1'b0} + bb3_pkg::NUM_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      count <= count_next;
      num   <= num_next;
    end
  end

  // Divide by 2*count: powers of two shift, 6, 12 and 18 go through a reciprocal
  always_comb begin
    recip   = bb3_pkg::RECIP3;
    use_mul = 1'b1;
    for (int ch = 0; ch < bb3_pkg::NUM_CHANS; ch++) begin
      div_in[ch]  = num[ch][bb3_pkg::NUM_W-1:1];
      shifted[ch] = bb3_pkg::CHAN_W'(num[ch] >> 1);
    end
    case (count)
      4'd1: begin
        use_mul = 1'b0;
      end
      4'd2: begin
        use_mul = 1'b0;
        for (int ch = 0; ch < bb3_pkg::NUM_CHANS; ch++) begin
          shifted[ch] = bb3_pkg::CHAN_W'(num[ch] >> 2);
        end
      end
      4'd4: begin
        use_mul = 1'b0;
        for (int ch = 0; ch < bb3_pkg::NUM_CHANS; ch++) begin
          shifted[ch] = bb3_pkg::CHAN_W'(num[ch] >> 3);
        end
      end
      4'd3: begin
        recip = bb3_pkg::RECIP3;
      end
      4'd6: begin
        recip = bb3_pkg::RECIP3;
        for (int ch = 0; ch < bb3_pkg::NUM_CHANS; ch++) begin
          div_in[ch] = bb3_pkg::SUM_W'(num[ch] >> 2);
        end
      end
      4'd9: begin
        recip = bb3_pkg::RECIP9;
      end
      default: begin
        use_mul = 1'b0;
      end
    endcase
    for (int ch = 0; ch < bb3_pkg::NUM_CHANS; ch++) begin
      prod[ch]      = bb3_pkg::PROD_W'(div_in[ch]) * bb3_pkg::PROD_W'(recip);
      mean_next[ch] = use_mul ?
                      prod[ch][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W] : shifted[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_mean) begin
      mean <= mean_next;
    end
  end

endmodule

// File: sv/bb3_merge.sv
module bb3_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  bb3_pkg::grp_t                 grp,
  input  bb3_pkg::lane_px_t             means,
  output logic                          can_load,
  output logic                          blur_valid,
  input  logic                          blur_ready,
  output logic [bb3_pkg::CHAN_W-1:0]    blur_red,
  output logic [bb3_pkg::CHAN_W-1:0]    blur_green,
  output logic [bb3_pkg::CHAN_W-1:0]    blur_blue,
  output logic [bb3_pkg::ROW_W-1:0]     out_row,
  output logic [bb3_pkg::OCOL_W-1:0]    out_col,
  output logic                          last_of_step,
  output logic                          frame_end
);

  logic [bb3_pkg::NUM_LANES-1:0] pending;
  logic [bb3_pkg::ROW_W-1:0]     row;
  logic [bb3_pkg::OCOL_W-1:0]    col;

  logic [1:0]                    sel;
  logic [bb3_pkg::NUM_LANES-1:0] rest;
  logic                          move;
  logic [bb3_pkg::ROW_W-1:0]     sel_row;
  logic [bb3_pkg::OCOL_W-1:0]    sel_col;

  // Lowest pending lane goes first: upper row before lower, left before right
  always_comb begin
    sel = 2'd0;
    for (int l = bb3_pkg::NUM_LANES - 1; l >= 0; l--) begin
      if (pending[l]) begin
        sel = 2'(l);
      end
    end
    rest       = pending;
    rest[sel]  = 1'b0;
    move       = (pending != '0) && (!blur_valid || blur_ready);
    can_load   = (pending == '0) || (move && rest == '0);
    sel_row    = sel[1] ? row : row - bb3_pkg::ROW_W'(1);
    sel_col    = sel[0] ? col : col - bb3_pkg::OCOL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      blur_valid <= 1'b0;
    end else begin
      if (load) begin
        pending <= grp.mask;
      end else if (move) begin
        pending <= rest;
      end
      if (move) begin
        blur_valid <= 1'b1;
      end else if (blur_ready) begin
        blur_valid <= 1'b0;
      end
    end
    if (load) begin
      row <= grp.row;
      col <= grp.col;
    end
    if (move) begin
      blur_red     <= means[sel][bb3_pkg::CH_RED];
      blur_green   <= means[sel][bb3_pkg::CH_GREEN];
      blur_blue    <= means[sel][bb3_pkg::CH_BLUE];
      out_row      <= sel_row;
      out_col      <= sel_col;
      last_of_step <= (rest == '0);
      frame_end    <= (sel == bb3_pkg::LANE_CORNER);
    end
  end

endmodule

// File: sv/box_blur_3x3.sv
// A pixel's results pass from the first stage through the lane sum and mean registers and
// the merge stage to the output register. Throughput: one pixel per clock while each pixel
// yields at most one result and the output is not stalled; the merge stage sends one result
// per cycle, so a pixel with k results (up to 4 at the frame's last pixel) holds the input.
// Reset (synchronous): counters to zero, width 1024, height 1, pipeline emptied.
// Row stores are not cleared; no initialisation pass, pixels are taken at once.
module box_blur_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [bb3_pkg::CHAN_W-1:0]    red,
  input  logic [bb3_pkg::CHAN_W-1:0]    green,
  input  logic [bb3_pkg::CHAN_W-1:0]    blue,
  output logic                          blur_valid,
  input  logic                          blur_ready,
  output logic [bb3_pkg::CHAN_W-1:0]    blur_red,
  output logic [bb3_pkg::CHAN_W-1:0]    blur_green,
  output logic [bb3_pkg::CHAN_W-1:0]    blur_blue,
  output logic [bb3_pkg::ROW_W-1:0]     out_row,
  output logic [bb3_pkg::OCOL_W-1:0]    out_col,
  output logic                          last_of_step,
  output logic                          frame_end
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [10:0]                image_width;
  logic [bb3_pkg::ROW_W-1:0]  image_height;
  logic [CW-1:0]              column_count;
  logic [bb3_pkg::ROW_W-1:0]  row_count;

  logic [WW-1:0]              width_raw;
  logic [WW-1:0]              width_eff;
  logic [bb3_pkg::ROW_W-1:0]  height_eff;
  logic                       lastcol_now;
  logic                       lastrow_now;
  logic                       pix_fire;

  logic                       s1_valid;
  bb3_pkg::pixel_t            s1_pix;
  logic [CW-1:0]              s1_col;
  logic [bb3_pkg::ROW_W-1:0]  s1_row;
  logic                       s1_lastcol;
  logic                       s1_lastrow;
  logic                       s1_fwd;
  bb3_pkg::pixel_t            s1_fwd_upper;
  bb3_pkg::pixel_t            s1_fwd_middle;
  logic                       s1_adv;

  bb3_pkg::pixel_t            upper_rd;
  bb3_pkg::pixel_t            middle_rd;
  bb3_pkg::pixel_t            cur_upper;
  bb3_pkg::pixel_t            cur_middle;

  bb3_pkg::column_t           win_far;
  bb3_pkg::column_t           win_near;
  bb3_pkg::win_t              win;

  logic [1:0]                 lane_row_skip [bb3_pkg::NUM_LANES];
  logic [1:0]                 lane_col_skip [bb3_pkg::NUM_LANES];
  bb3_pkg::grp_t              grp_next;

  logic                       s2_valid;
  bb3_pkg::grp_t              s2_grp;
  logic                       s2_adv;
  logic                       merge_can_load;

  bb3_pkg::lane_ctrl_t        lane_ctrl;
  bb3_pkg::lane_px_t          lane_mean;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb3_pkg::IMAGE_WIDTH_RESET;
      image_height <= bb3_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bb3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        bb3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame width to what the row stores hold; a zero width or height counts as 1
  always_comb begin
    width_raw = WW'(image_width);
    if (width_raw == '0) begin
      width_eff = WW'(1);
    end else if (width_raw > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    height_eff  = (image_height == '0) ? bb3_pkg::ROW_W'(1) : image_height;
    lastcol_now = (WW'(column_count) + WW'(1)) >= width_eff;
    lastrow_now = ({1'b0, row_count} + 17'd1) >= {1'b0, height_eff};
  end

  assign s2_adv    = s2_valid && merge_can_load;
  assign s1_adv    = s1_valid && (!s2_valid || s2_adv);
  assign pix_ready = !s1_valid || s1_adv;
  assign pix_fire  = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pix_fire) begin
      if (lastcol_now) begin
        column_count <= '0;
        row_count    <= lastrow_now ? '0 : row_count + bb3_pkg::ROW_W'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Same-column write landing on the read edge: take the written word instead
  assign cur_upper  = s1_fwd ? s1_fwd_upper  : upper_rd;
  assign cur_middle = s1_fwd ? s1_fwd_middle : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (pix_fire) begin
      s1_pix        <= {red, green, blue};
      s1_col        <= column_count;
      s1_row        <= row_count;
      s1_lastcol    <= lastcol_now;
      s1_lastrow    <= lastrow_now;
      s1_fwd        <= s1_adv && (s1_col == column_count);
      s1_fwd_upper  <= cur_middle;
      s1_fwd_middle <= s1_pix;
    end
    if (s1_adv) begin
      win_far  <= win_near;
      win_near <= {s1_pix, cur_middle, cur_upper};
    end
  end

  bb3_ram #(
    .WIDTH (bb3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (cur_middle),
    .re    (pix_fire),
    .raddr (column_count),
    .rdata (upper_rd)
  );

  bb3_ram #(
    .WIDTH (bb3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (pix_fire),
    .raddr (column_count),
    .rdata (middle_rd)
  );

  assign win = {{s1_pix, cur_middle, cur_upper}, win_near, win_far};

  // Lane bit 1 picks the output row (one up, or this row at the bottom),
  // lane bit 0 the output column (one left, or this column at the right edge)
  always_comb begin
    for (int l = 0; l < bb3_pkg::NUM_LANES; l++) begin
      if (l[1]) begin
        lane_row_skip[l] = (s1_row != '0) ? 2'd1 : 2'd2;
        grp_next.mask[l] = s1_lastrow;
      end else begin
        lane_row_skip[l] = (s1_row >= bb3_pkg::ROW_W'(2)) ? 2'd0 : 2'd1;
        grp_next.mask[l] = (s1_row != '0);
      end
      if (l[0]) begin
        lane_col_skip[l] = (s1_col != '0) ? 2'd1 : 2'd2;
        grp_next.mask[l] = grp_next.mask[l] && s1_lastcol;
      end else begin
        lane_col_skip[l] = (s1_col >= CW'(2)) ? 2'd0 : 2'd1;
        grp_next.mask[l] = grp_next.mask[l] && (s1_col != '0);
      end
    end
    grp_next.row = s1_row;
    grp_next.col = bb3_pkg::OCOL_W'(s1_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
    if (s1_adv) begin
      s2_grp <= grp_next;
    end
  end

  assign lane_ctrl.load_sum  = s1_adv;
  assign lane_ctrl.load_mean = s2_adv;

  for (genvar l = 0; l < bb3_pkg::NUM_LANES; l++) begin : g_lane
    bb3_lane u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .win      (win),
      .row_skip (lane_row_skip[l]),
      .col_skip (lane_col_skip[l]),
      .mean     (lane_mean[l])
    );
  end

  bb3_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (s2_adv),
    .grp          (s2_grp),
    .means        (lane_mean),
    .can_load     (merge_can_load),
    .blur_valid   (blur_valid),
    .blur_ready   (blur_ready),
    .blur_red     (blur_red),
    .blur_green   (blur_green),
    .blur_blue    (blur_blue),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_step (last_of_step),
    .frame_end    (frame_end)
  );

`ifndef SYNTHESIS
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    blur_valid && frame_end |-> last_of_step)
    else $error("frame end not on the last result of its pixel");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(s1_pix))
    else $error("stalled pixel lost in first stage");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_adv |=> s2_valid && $stable(s2_grp))
    else $error("stalled group lost before merge");
`endif

endmodule
